// ===== sv/linear_probe_hash_table_unit_macros.svh =====
// Assertion macros shared by the hash table checker.
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LPHT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LPHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lpht_pkg.sv =====
// Shared types, constants and helpers for the linear probe hash table.
package lpht_pkg;

    localparam int CAPACITY_LOG2 = 12;
    localparam int SLOTS         = 1 << CAPACITY_LOG2;
    localparam int FILL_NUM      = 7;
    localparam int FILL_DEN      = 10;
    localparam int FILL_LIMIT    = (SLOTS * FILL_NUM) / FILL_DEN;
    localparam int COUNT_W       = CAPACITY_LOG2 + 1;
    localparam int FILL_W        = 13;
    localparam int KEY_W         = 64;
    localparam int VALUE_W       = 8;

    localparam logic [63:0] HASH_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] HASH_MUL1  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] HASH_MUL2  = 64'h94d049bb133111eb;
    localparam int          HASH_SHIFT1 = 30;
    localparam int          HASH_SHIFT2 = 27;
    localparam int          HASH_SHIFT3 = 31;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    typedef logic [CAPACITY_LOG2-1:0] slot_t;
    typedef logic [COUNT_W-1:0]       count_t;
    typedef logic [KEY_W-1:0]         tag_t;
    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [FILL_W-1:0]        fill_t;

    typedef struct packed {
        tag_t   tag;
        value_t value;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_HIT     = 3'd0,
        ST_MISS    = 3'd1,
        ST_NEW     = 3'd2,
        ST_UPDATED = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    // Fit the occupancy count to the reported width, wrapping when wider.
    function automatic fill_t fill_out(input count_t c);
        logic [FILL_W+COUNT_W-1:0] wide;
        wide = {{FILL_W{1'b0}}, c};
        return wide[FILL_W-1:0];
    endfunction

endpackage

// ===== sv/lpht_hash.sv =====
// Five-stage splitmix64 finalizer pipeline producing the start slot.
module lpht_hash (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  lpht_pkg::tag_t       key,
    output logic                 done,
    output lpht_pkg::slot_t      slot
);

    logic [4:0] vld_reg;
    logic [4:0] vld_next;

    logic [63:0] z1_reg, z1_next;
    logic [63:0] pll2_reg, pll2_next;
    logic [31:0] phl2_reg, phl2_next;
    logic [31:0] plh2_reg, plh2_next;
    logic [63:0] z3_reg, z3_next;
    logic [63:0] pll4_reg, pll4_next;
    logic [31:0] phl4_reg, phl4_next;
    logic [31:0] plh4_reg, plh4_next;
    lpht_pkg::slot_t slot_reg, slot_next;

    logic [63:0] z0;
    logic [63:0] sum3;
    logic [63:0] sum5;
    logic [63:0] z5;

    always_comb
    begin
        vld_next = {vld_reg[3:0], start};

        z0      = key + lpht_pkg::HASH_GAMMA;
        z1_next = z0 ^ (z0 >> lpht_pkg::HASH_SHIFT1);

        // first multiply, split into 32-bit partial products
        pll2_next = z1_reg[31:0] * lpht_pkg::HASH_MUL1[31:0];
        phl2_next = z1_reg[63:32] * lpht_pkg::HASH_MUL1[31:0];
        plh2_next = z1_reg[31:0] * lpht_pkg::HASH_MUL1[63:32];

        sum3    = pll2_reg + {phl2_reg + plh2_reg, 32'd0};
        z3_next = sum3 ^ (sum3 >> lpht_pkg::HASH_SHIFT2);

        pll4_next = z3_reg[31:0] * lpht_pkg::HASH_MUL2[31:0];
        phl4_next = z3_reg[63:32] * lpht_pkg::HASH_MUL2[31:0];
        plh4_next = z3_reg[31:0] * lpht_pkg::HASH_MUL2[63:32];

        sum5      = pll4_reg + {phl4_reg + plh4_reg, 32'd0};
        z5        = sum5 ^ (sum5 >> lpht_pkg::HASH_SHIFT3);
        slot_next = z5[lpht_pkg::CAPACITY_LOG2-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        z1_reg   <= z1_next;
        pll2_reg <= pll2_next;
        phl2_reg <= phl2_next;
        plh2_reg <= plh2_next;
        z3_reg   <= z3_next;
        pll4_reg <= pll4_next;
        phl4_reg <= phl4_next;
        plh4_reg <= plh4_next;
        slot_reg <= slot_next;
    end

    assign done = vld_reg[4];
    assign slot = slot_reg;

endmodule

// ===== sv/lpht_ram.sv =====
// Simple dual-port RAM with one write port and a registered read port.
module lpht_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 72
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/linear_probe_hash_table_unit.sv =====
// Top level of the linear probe hash table: probe sequencer, slot RAM, result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  req     | in        | req_valid, req_stall | command, key, value_in
//  rsp     | out       | rsp_valid, rsp_stall | status, value_out, fill_count
//
// A new item is not taken until the last one has left the sequencer; the
// time from one acceptance to the next grows with each further probe and is
// set by the 5-stage hash pipeline and one RAM read per probe. An all-ones
// key skips the hash and the probe.
// After reset, a clearing pass writes every one of the 4096 slots empty, one per
// cycle; req_stall stays high until the pass is done.
// A stalled result holds in the output register; the next request is still
// taken, and its result waits in the sequencer until the register frees up.
module linear_probe_hash_table_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic               command,
    input  logic [63:0]        key,
    input  logic signed [7:0]  value_in,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [2:0]         status,
    output logic signed [7:0]  value_out,
    output logic [12:0]        fill_count
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_CHECK,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;

    // request being worked on
    logic                      cmd_reg, cmd_next;
    lpht_pkg::tag_t            tag_reg, tag_next;
    lpht_pkg::value_t          val_reg, val_next;
    lpht_pkg::slot_t           pos_reg, pos_next;
    lpht_pkg::slot_t           probes_reg, probes_next;
    lpht_pkg::slot_t           clr_reg, clr_next;
    lpht_pkg::count_t          count_reg, count_next;

    // finished result waiting for the output register
    lpht_pkg::status_t         pend_status_reg, pend_status_next;
    lpht_pkg::value_t          pend_value_reg, pend_value_next;
    lpht_pkg::count_t          pend_fill_reg, pend_fill_next;

    // output register
    logic                      rsp_valid_reg, rsp_valid_next;
    lpht_pkg::status_t         rsp_status_reg, rsp_status_next;
    lpht_pkg::value_t          rsp_value_reg, rsp_value_next;
    lpht_pkg::fill_t           rsp_fill_reg, rsp_fill_next;

    // slot RAM ports
    logic                      ram_wr_en;
    lpht_pkg::slot_t           ram_wr_addr;
    lpht_pkg::entry_t          ram_wr_data;
    logic                      ram_rd_en;
    lpht_pkg::slot_t           ram_rd_addr;
    logic [lpht_pkg::ENTRY_W-1:0] ram_rd_bits;

    // hash pipeline
    logic                      hash_start;
    logic                      hash_done;
    lpht_pkg::slot_t           hash_slot;

    lpht_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (key),
        .done  (hash_done),
        .slot  (hash_slot)
    );

    lpht_ram #(
        .ADDR_W (lpht_pkg::CAPACITY_LOG2),
        .DATA_W (lpht_pkg::ENTRY_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_bits)
    );

    always_comb
    begin
        lpht_pkg::entry_t ent;
        logic             slot_empty;
        logic             slot_match;
        logic             out_free;

        state_next       = state_reg;
        cmd_next         = cmd_reg;
        tag_next         = tag_reg;
        val_next         = val_reg;
        pos_next         = pos_reg;
        probes_next      = probes_reg;
        clr_next         = clr_reg;
        count_next       = count_reg;
        pend_status_next = pend_status_reg;
        pend_value_next  = pend_value_reg;
        pend_fill_next   = pend_fill_reg;
        rsp_valid_next   = rsp_valid_reg;
        rsp_status_next  = rsp_status_reg;
        rsp_value_next   = rsp_value_reg;
        rsp_fill_next    = rsp_fill_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = pos_reg;
        ram_wr_data = '{tag: tag_reg, value: val_reg};
        ram_rd_en   = 1'b0;
        ram_rd_addr = pos_reg + lpht_pkg::slot_t'(1);
        hash_start  = 1'b0;

        ent        = ram_rd_bits;
        slot_empty = (ent.tag == '0);
        slot_match = (ent.tag == tag_reg);

        // drop the output beat once it is taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        out_free = !rsp_valid_reg || !rsp_stall;

        case (state_reg)
            S_CLEAR:
            begin
                // sweep the RAM once, marking every slot empty
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_reg;
                ram_wr_data = '0;
                clr_next    = clr_reg + lpht_pkg::slot_t'(1);
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next = command;
                    tag_next = key + 64'd1;
                    val_next = value_in;
                    if (&key)
                    begin
                        // all-ones key has no stored form: answer without probing
                        pend_status_next = (command == lpht_pkg::CMD_INSERT) ?
                                           lpht_pkg::ST_FULL : lpht_pkg::ST_MISS;
                        pend_value_next  = '0;
                        pend_fill_next   = count_reg;
                        state_next       = S_EMIT;
                    end
                    else
                    begin
                        hash_start = 1'b1;
                        state_next = S_HASH;
                    end
                end
            end

            S_HASH:
            begin
                // issue the first probe as soon as the start slot is out
                if (hash_done)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = hash_slot;
                    pos_next    = hash_slot;
                    probes_next = '0;
                    state_next  = S_CHECK;
                end
            end

            S_CHECK:
            begin
                pend_value_next = '0;
                pend_fill_next  = count_reg;
                if (slot_match)
                begin
                    if (cmd_reg == lpht_pkg::CMD_LOOKUP)
                    begin
                        pend_status_next = lpht_pkg::ST_HIT;
                        pend_value_next  = ent.value;
                    end
                    else
                    begin
                        // rewrite the entry with the new value
                        ram_wr_en        = 1'b1;
                        pend_status_next = lpht_pkg::ST_UPDATED;
                    end
                    state_next = S_EMIT;
                end
                else if (slot_empty || (&probes_reg))
                begin
                    // empty slot ends the search; a full sweep without one is a cap
                    if (cmd_reg == lpht_pkg::CMD_LOOKUP)
                    begin
                        pend_status_next = lpht_pkg::ST_MISS;
                    end
                    else if (!slot_empty ||
                             (count_reg >= lpht_pkg::count_t'(lpht_pkg::FILL_LIMIT)))
                    begin
                        pend_status_next = lpht_pkg::ST_FULL;
                    end
                    else
                    begin
                        ram_wr_en        = 1'b1;
                        count_next       = count_reg + lpht_pkg::count_t'(1);
                        pend_fill_next   = count_reg + lpht_pkg::count_t'(1);
                        pend_status_next = lpht_pkg::ST_NEW;
                    end
                    state_next = S_EMIT;
                end
                else
                begin
                    // advance to the next slot, wrapping at the top
                    ram_rd_en   = 1'b1;
                    pos_next    = pos_reg + lpht_pkg::slot_t'(1);
                    probes_next = probes_reg + lpht_pkg::slot_t'(1);
                end
            end

            S_EMIT:
            begin
                // hold the result until the output register frees up
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = pend_status_reg;
                    rsp_value_next  = pend_value_reg;
                    rsp_fill_next   = lpht_pkg::fill_out(pend_fill_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        tag_reg         <= tag_next;
        val_reg         <= val_next;
        pos_reg         <= pos_next;
        probes_reg      <= probes_next;
        pend_status_reg <= pend_status_next;
        pend_value_reg  <= pend_value_next;
        pend_fill_reg   <= pend_fill_next;
        rsp_status_reg  <= rsp_status_next;
        rsp_value_reg   <= rsp_value_next;
        rsp_fill_reg    <= rsp_fill_next;
    end

    assign req_stall  = (state_reg != S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign status     = rsp_status_reg;
    assign value_out  = rsp_value_reg;
    assign fill_count = rsp_fill_reg;

endmodule

// ===== sv/lpht_checker.sv =====
// Port-level checker for the linear probe hash table, bound to the top level.
`include "linear_probe_hash_table_unit_macros.svh"

module lpht_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_stall,
    input  logic              rsp_valid,
    input  logic              rsp_stall,
    input  logic [2:0]        status,
    input  logic signed [7:0] value_out,
    input  logic [12:0]       fill_count
);

    logic [12:0] last_fill_reg;
    logic [12:0] fill_plus1;

    // track the fill count of the last delivered beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_fill_reg <= '0;
        end
        else if (rsp_valid && !rsp_stall)
        begin
            last_fill_reg <= fill_count;
        end
    end

    assign fill_plus1 = last_fill_reg + 13'd1;

    `LPHT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(status) && $stable(value_out) && $stable(fill_count), "stalled response beat changed")

    `LPHT_ASSERT_NOW(a_value_zero, rsp_valid && (status != lpht_pkg::ST_HIT), value_out == 8'sd0, "value_out nonzero on a non-hit result")

    `LPHT_ASSERT_NOW(a_fill_new, rsp_valid && (status == lpht_pkg::ST_NEW), fill_count == fill_plus1, "new insert did not raise fill count by one")

    `LPHT_ASSERT_NOW(a_fill_keep, rsp_valid && (status != lpht_pkg::ST_NEW), fill_count == last_fill_reg, "fill count moved without a new insert")

    `LPHT_ASSERT_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall, "request taken while one is in flight")

endmodule

bind linear_probe_hash_table_unit lpht_checker u_lpht_checker (.*);

// ===== tb/linear_probe_hash_table_unit_tb.sv =====
// Self-checking testbench for the linear probe hash table unit.
module linear_probe_hash_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Run ends with a failure if this many cycles pass.
    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam logic [63:0] ALL_ONES_KEY = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          REPORT_MAX   = 10;

    // One expected response beat.
    typedef struct {
        lpht_pkg::status_t code;
        lpht_pkg::value_t  stored;
        lpht_pkg::fill_t   fill;
    } answer_t;

    // Mirror of the slot table: predicts every response and checks it in order.
    class hash_table_mirror;
        bit [63:0]         key_slots [lpht_pkg::SLOTS];
        lpht_pkg::value_t  value_slots [lpht_pkg::SLOTS];
        int unsigned       occupancy;
        answer_t           pending_answers [$];
        int unsigned       mismatch_count;

        // Home slot: splitmix64 finalizer of the key, masked to the table size.
        function lpht_pkg::slot_t home_slot(logic [63:0] k);
            logic [63:0] z;
            z = k + lpht_pkg::HASH_GAMMA;
            z = (z ^ (z >> lpht_pkg::HASH_SHIFT1)) * lpht_pkg::HASH_MUL1;
            z = (z ^ (z >> lpht_pkg::HASH_SHIFT2)) * lpht_pkg::HASH_MUL2;
            z = z ^ (z >> lpht_pkg::HASH_SHIFT3);
            return z[lpht_pkg::CAPACITY_LOG2-1:0];
        endfunction

        // Apply an accepted request to the mirror and queue its response.
        function lpht_pkg::status_t note_request(logic cmd, logic [63:0] k,
                                                 lpht_pkg::value_t v);
            answer_t          a;
            logic [63:0]      tag;
            lpht_pkg::slot_t  pos;
            int               steps;
            bit               found;
            bit               vacant;
            a.stored = '0;
            tag      = k + 64'd1;
            found    = 1'b0;
            vacant   = 1'b0;
            if (tag == '0)
            begin
                // All-ones key wraps onto the empty mark: never touches the table.
                a.code = (cmd == lpht_pkg::CMD_INSERT) ? lpht_pkg::ST_FULL : lpht_pkg::ST_MISS;
            end
            else
            begin
                pos = home_slot(k);
                for (steps = 0; steps < lpht_pkg::SLOTS && !found && !vacant; steps++)
                begin
                    if (key_slots[pos] == tag)
                        found = 1'b1;
                    else if (key_slots[pos] == '0)
                        vacant = 1'b1;
                    else
                        pos = pos + lpht_pkg::slot_t'(1);
                end
                if (cmd == lpht_pkg::CMD_LOOKUP)
                begin
                    if (found)
                    begin
                        a.code   = lpht_pkg::ST_HIT;
                        a.stored = value_slots[pos];
                    end
                    else
                        a.code = lpht_pkg::ST_MISS;
                end
                else if (found)
                begin
                    value_slots[pos] = v;
                    a.code           = lpht_pkg::ST_UPDATED;
                end
                else if (!vacant || (occupancy + 1) * 10 > lpht_pkg::SLOTS * 7)
                    a.code = lpht_pkg::ST_FULL;
                else
                begin
                    key_slots[pos]   = tag;
                    value_slots[pos] = v;
                    occupancy++;
                    a.code = lpht_pkg::ST_NEW;
                end
            end
            a.fill = lpht_pkg::fill_t'(occupancy);
            pending_answers.push_back(a);
            return a.code;
        endfunction

        // Compare one accepted response beat against the oldest prediction.
        function void check_response(logic [2:0] got_code, lpht_pkg::value_t got_value,
                                     lpht_pkg::fill_t got_fill);
            answer_t want;
            if (pending_answers.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("%0t: response with nothing pending: %s %0d value %0d fill %0d",
                             $realtime, "status", got_code, got_value, got_fill);
                return;
            end
            want = pending_answers.pop_front();
            if (got_code !== want.code || got_value !== want.stored ||
                got_fill !== want.fill)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("%0t: response mismatch: expected status %0d value %0d fill %0d, %s",
                             $realtime, want.code, want.stored, want.fill,
                             $sformatf("got status %0d value %0d fill %0d",
                                       got_code, got_value, got_fill));
            end
        endfunction
    endclass

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               req_valid  = 1'b0;
    logic               req_stall;
    logic               command    = lpht_pkg::CMD_LOOKUP;
    logic [63:0]        key        = '0;
    logic signed [7:0]  value_in   = '0;
    logic               rsp_valid;
    logic               rsp_stall  = 1'b0;
    logic [2:0]         status;
    logic signed [7:0]  value_out;
    logic [12:0]        fill_count;

    hash_table_mirror board = new;

    // Keys known to be in the table, for hits and updates.
    logic [63:0] stored_keys [$];

    // Idle odds in percent per cycle, changed between traffic phases.
    int sender_idle_pct    = 26;
    int receiver_stall_pct = 67;

    int unsigned cycle_count = 0;

    linear_probe_hash_table_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .command    (command),
        .key        (key),
        .value_in   (value_in),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .status     (status),
        .value_out  (value_out),
        .fill_count (fill_count)
    );

    always #5 clk = ~clk;

    // Watchdog: stop a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver back-pressure: redraw the stall every cycle, independent of rsp_valid.
    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < receiver_stall_pct);

    // Response monitor: a beat moves when rsp_valid is high and rsp_stall is low
    // at the edge. Values read here are the ones from before the edge.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid === 1'b1 && rsp_stall == 1'b0)
            board.check_response(status, value_out, fill_count);
    end

    // Drive one request beat, with random idle cycles ahead of it. Hold the
    // payload until the beat is taken, then advance the mirror.
    task automatic issue(input logic cmd, input logic [63:0] k,
                         input lpht_pkg::value_t v);
        lpht_pkg::status_t outcome;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        command   <= cmd;
        key       <= k;
        value_in  <= v;
        @(posedge clk);
        // X on req_stall counts as a stall.
        while (req_stall !== 1'b0)
            @(posedge clk);
        outcome = board.note_request(cmd, k, v);
        if (outcome == lpht_pkg::ST_NEW)
            stored_keys.push_back(k);
    endtask

    function automatic logic [63:0] fresh_key();
        return {$urandom, $urandom};
    endfunction

    function automatic lpht_pkg::value_t any_value();
        return lpht_pkg::value_t'($urandom);
    endfunction

    function automatic logic [63:0] pick_stored();
        return stored_keys[$urandom_range(stored_keys.size() - 1)];
    endfunction

    // Search upward from a seed for a key whose probe starts at the given slot.
    function automatic logic [63:0] key_homing_to(lpht_pkg::slot_t target,
                                                  logic [63:0] seed);
        logic [63:0] k;
        k = seed;
        while (board.home_slot(k) != target)
            k = k + 64'd1;
        return k;
    endfunction

    // Mixed traffic at low to moderate load: new keys, updates, hits, misses,
    // and now and then the all-ones key.
    task automatic mixed_traffic(input int count);
        int roll;
        repeat (count)
        begin
            roll = $urandom_range(99);
            if (roll < 40)
                issue(lpht_pkg::CMD_INSERT, fresh_key(), any_value());
            else if (roll < 55)
                issue(lpht_pkg::CMD_INSERT, pick_stored(), any_value());
            else if (roll < 80)
                issue(lpht_pkg::CMD_LOOKUP, pick_stored(), any_value());
            else if (roll < 95)
                issue(lpht_pkg::CMD_LOOKUP, fresh_key(), any_value());
            else
                issue($urandom_range(1) == 1, ALL_ONES_KEY, any_value());
        end
    endtask

    initial
    begin
        logic [63:0] wrap_a;
        logic [63:0] wrap_b;
        logic [63:0] wrap_c;
        logic [63:0] wrap_d;

        // Hold reset low at the start, then release it; the block then runs its clearing pass with
        // req_stall high, which the first request simply waits out.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // ---- Directed part (sender idles 26%, receiver stalls 67%) ----
        // Empty table miss, with a nonzero value that a lookup must ignore.
        issue(lpht_pkg::CMD_LOOKUP, 64'd0, lpht_pkg::value_t'(8'h55));
        // Smallest key: insert, hit, update, hit again at both value extremes.
        issue(lpht_pkg::CMD_INSERT, 64'd0, lpht_pkg::value_t'(-128));
        issue(lpht_pkg::CMD_LOOKUP, 64'd0, lpht_pkg::value_t'(0));
        issue(lpht_pkg::CMD_INSERT, 64'd0, lpht_pkg::value_t'(127));
        issue(lpht_pkg::CMD_LOOKUP, 64'd0, lpht_pkg::value_t'(-1));
        // All-ones key aliases the empty mark: insert rejected, lookup misses.
        issue(lpht_pkg::CMD_INSERT, ALL_ONES_KEY, lpht_pkg::value_t'(5));
        issue(lpht_pkg::CMD_LOOKUP, ALL_ONES_KEY, lpht_pkg::value_t'(0));
        // Largest storable key.
        issue(lpht_pkg::CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFE, lpht_pkg::value_t'(-1));
        issue(lpht_pkg::CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, lpht_pkg::value_t'(0));

        // Collisions on the top slot: the second key wraps to slot 0, and a key
        // homing on slot 0 is pushed further along the same run.
        wrap_a = key_homing_to(lpht_pkg::slot_t'(lpht_pkg::SLOTS - 1), fresh_key());
        wrap_b = key_homing_to(lpht_pkg::slot_t'(lpht_pkg::SLOTS - 1), wrap_a + 64'd1);
        wrap_c = key_homing_to(lpht_pkg::slot_t'(0), fresh_key());
        wrap_d = key_homing_to(lpht_pkg::slot_t'(lpht_pkg::SLOTS - 1), wrap_b + 64'd1);
        issue(lpht_pkg::CMD_INSERT, wrap_a, lpht_pkg::value_t'(1));
        issue(lpht_pkg::CMD_INSERT, wrap_b, lpht_pkg::value_t'(2));
        issue(lpht_pkg::CMD_INSERT, wrap_c, lpht_pkg::value_t'(3));
        issue(lpht_pkg::CMD_LOOKUP, wrap_b, lpht_pkg::value_t'(0));
        issue(lpht_pkg::CMD_LOOKUP, wrap_c, lpht_pkg::value_t'(0));
        // Miss that walks the whole wrapped run before hitting an empty slot.
        issue(lpht_pkg::CMD_LOOKUP, wrap_d, lpht_pkg::value_t'(0));
        issue(lpht_pkg::CMD_INSERT, wrap_c, lpht_pkg::value_t'(-3));
        issue(lpht_pkg::CMD_LOOKUP, wrap_c, lpht_pkg::value_t'(0));

        // ---- Random part, three idle profiles ----
        mixed_traffic(170);

        sender_idle_pct    = 67;
        receiver_stall_pct = 26;
        mixed_traffic(170);

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        mixed_traffic(160);

        // Closing mix with neither side idling: new keys, updates, hits,
        // misses and one more all-ones insert.
        repeat (12) issue(lpht_pkg::CMD_INSERT, fresh_key(), any_value());
        repeat (8)  issue(lpht_pkg::CMD_INSERT, pick_stored(), any_value());
        repeat (8)  issue(lpht_pkg::CMD_LOOKUP, pick_stored(), any_value());
        repeat (8)  issue(lpht_pkg::CMD_LOOKUP, fresh_key(), any_value());
        issue(lpht_pkg::CMD_INSERT, ALL_ONES_KEY, any_value());
        req_valid <= 1'b0;

        // Drain, then give any stray beat time to show up.
        while (board.pending_answers.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (board.mismatch_count == 0 && board.pending_answers.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
